// ----- src/wwcp_pkg.sv -----
// Shared types and constants for the waveform window charge and peak block.
package wwcp_pkg;

    // Longest waveform the sample counter tracks; later samples fall in no window
    localparam int unsigned MAX_SAMPLES = 32768;
    localparam int unsigned IDX_W       = $clog2(MAX_SAMPLES + 1);

    // Register file geometry
    localparam int unsigned WIN_W  = 15;
    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    // Datapath widths
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned CHAN_W   = 4;
    localparam int unsigned SUM_W    = 31;

    // Register indexes (byte address / 4)
    typedef enum logic [1:0] {
        REG_SIGNAL_START   = 2'd0,
        REG_SIGNAL_END     = 2'd1,
        REG_BASELINE_START = 2'd2,
        REG_BASELINE_END   = 2'd3
    } t_reg_idx;

    // Window bounds handed from the register file to the datapath
    typedef struct packed {
        logic [WIN_W-1:0] sig_lo;
        logic [WIN_W-1:0] sig_hi;
        logic [WIN_W-1:0] base_lo;
        logic [WIN_W-1:0] base_hi;
    } t_windows;

endpackage

// ----- src/wwcp_regs.sv -----
// APB register file holding the four window bounds.
module wwcp_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wwcp_pkg::ADDR_W-1:0]         paddr,
    input  logic [wwcp_pkg::DATA_W-1:0]         pwdata,
    output logic [wwcp_pkg::DATA_W-1:0]         prdata,
    output logic                                pready,
    output wwcp_pkg::t_windows                  o_windows
);

    wwcp_pkg::t_windows              r_win;
    wwcp_pkg::t_reg_idx              reg_idx;
    logic                            wr_en;
    logic [wwcp_pkg::WIN_W-1:0]      wr_val;
    logic [wwcp_pkg::WIN_W-1:0]      rd_val;

    assign pready  = 1'b1;
    assign reg_idx = wwcp_pkg::t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;
    // upper data bits are ignored
    assign wr_val  = pwdata[wwcp_pkg::WIN_W-1:0];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                wwcp_pkg::REG_SIGNAL_START:   r_win.sig_lo  <= wr_val;
                wwcp_pkg::REG_SIGNAL_END:     r_win.sig_hi  <= wr_val;
                wwcp_pkg::REG_BASELINE_START: r_win.base_lo <= wr_val;
                wwcp_pkg::REG_BASELINE_END:   r_win.base_hi <= wr_val;
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (reg_idx)
            wwcp_pkg::REG_SIGNAL_START:   rd_val = r_win.sig_lo;
            wwcp_pkg::REG_SIGNAL_END:     rd_val = r_win.sig_hi;
            wwcp_pkg::REG_BASELINE_START: rd_val = r_win.base_lo;
            wwcp_pkg::REG_BASELINE_END:   rd_val = r_win.base_hi;
            default:                      rd_val = '0;
        endcase
    end

    assign prdata    = {{(wwcp_pkg::DATA_W - wwcp_pkg::WIN_W){1'b0}}, rd_val};
    assign o_windows = r_win;

endmodule

// ----- src/waveform_window_charge_peak.sv -----
// Top level: per-channel window charge integral and peak of a digitizer waveform.
//
// Input channel: one signed 16-bit sample per item with its channel tag and a
// last-sample flag, handshaked by i_valid / o_stall. Samples are numbered from
// 0 within each waveform. Output channel: one result item per waveform
// (channel tag, signal sum, baseline sum, peak, peak_found) on o_valid / i_stall.
// The user sets window bounds over the APB port while idle; no check in the block.
//
// Throughput, but for a stalled last sample, is one sample per cycle: the window
// compares and the two 31-bit accumulator adds sit between the accepted sample
// and the state registers. A result is registered in the cycle after its last
// sample is accepted; while it waits in the output register, ordinary samples
// are still taken and only a further last sample is stalled until the output
// drains. Reset clears the window registers, accumulators and output valid.
module waveform_window_charge_peak (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // sample input
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [wwcp_pkg::SAMPLE_W-1:0] i_sample,
    input  logic        [wwcp_pkg::CHAN_W-1:0]   i_channel,
    input  logic                                 i_last_sample,
    // result output
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic        [wwcp_pkg::CHAN_W-1:0]   o_channel_out,
    output logic signed [wwcp_pkg::SUM_W-1:0]    o_signal_sum,
    output logic signed [wwcp_pkg::SUM_W-1:0]    o_baseline_sum,
    output logic signed [wwcp_pkg::SAMPLE_W-1:0] o_peak,
    output logic                                 o_peak_found,
    // configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [wwcp_pkg::ADDR_W-1:0]          paddr,
    input  logic [wwcp_pkg::DATA_W-1:0]          pwdata,
    output logic [wwcp_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready
);

    localparam logic [wwcp_pkg::IDX_W-1:0] IdxMax = wwcp_pkg::IDX_W'(wwcp_pkg::MAX_SAMPLES);

    wwcp_pkg::t_windows win;

    // waveform state
    logic        [wwcp_pkg::IDX_W-1:0]    r_index,    n_index;
    logic signed [wwcp_pkg::SUM_W-1:0]    r_sig_acc,  n_sig_acc;
    logic signed [wwcp_pkg::SUM_W-1:0]    r_base_acc, n_base_acc;
    logic signed [wwcp_pkg::SAMPLE_W-1:0] r_peak,     n_peak;
    logic                                 r_peak_seen, n_peak_seen;

    // output register
    logic                                 r_out_valid;
    logic        [wwcp_pkg::CHAN_W-1:0]   r_out_chan;
    logic signed [wwcp_pkg::SUM_W-1:0]    r_out_sig;
    logic signed [wwcp_pkg::SUM_W-1:0]    r_out_base;
    logic signed [wwcp_pkg::SAMPLE_W-1:0] r_out_peak;
    logic                                 r_out_found;

    logic accept, accept_last;
    logic in_range, in_sig, in_base, in_peak, take_peak;
    logic signed [wwcp_pkg::SUM_W-1:0] sample_ext;

    wwcp_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_windows (win)
    );

    // a last sample waits only while a result is held by the receiver
    assign o_stall     = r_out_valid && i_stall && i_last_sample;
    assign accept      = i_valid && !o_stall;
    assign accept_last = accept && i_last_sample;

    // window membership of the current sample index
    assign in_range = r_index < IdxMax;
    assign in_sig   = in_range
                   && (r_index >= {1'b0, win.sig_lo})
                   && (r_index <  {1'b0, win.sig_hi});
    assign in_base  = in_range
                   && (r_index >= {1'b0, win.base_lo})
                   && (r_index <  {1'b0, win.base_hi});
    assign in_peak  = in_range
                   && (r_index >= {1'b0, win.sig_lo})
                   && (r_index <= {1'b0, win.sig_hi});
    // strict compare keeps the first maximum
    assign take_peak = in_peak && (!r_peak_seen || (i_sample > r_peak));

    assign sample_ext = wwcp_pkg::SUM_W'(i_sample);

    // state update for the accepted sample
    always_comb begin
        n_index     = in_range ? r_index + 1'b1 : r_index;
        n_sig_acc   = in_sig  ? r_sig_acc  + sample_ext : r_sig_acc;
        n_base_acc  = in_base ? r_base_acc + sample_ext : r_base_acc;
        n_peak      = take_peak ? i_sample : r_peak;
        n_peak_seen = r_peak_seen || in_peak;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || accept_last) begin
            r_index     <= '0;
            r_sig_acc   <= '0;
            r_base_acc  <= '0;
            r_peak      <= '0;
            r_peak_seen <= 1'b0;
        end else if (accept) begin
            r_index     <= n_index;
            r_sig_acc   <= n_sig_acc;
            r_base_acc  <= n_base_acc;
            r_peak      <= n_peak;
            r_peak_seen <= n_peak_seen;
        end
    end

    // result register: valid control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register: payload
    always_ff @(posedge i_clk) begin
        if (accept_last) begin
            r_out_chan  <= i_channel;
            r_out_sig   <= n_sig_acc;
            r_out_base  <= n_base_acc;
            r_out_peak  <= n_peak_seen ? n_peak : '0;
            r_out_found <= n_peak_seen;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_channel_out  = r_out_chan;
    assign o_signal_sum   = r_out_sig;
    assign o_baseline_sum = r_out_base;
    assign o_peak         = r_out_peak;
    assign o_peak_found   = r_out_found;

    // a finished waveform always lands in the output register
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept_last |=> r_out_valid)
        else $error("last sample accepted without a result");

    // a finished waveform restarts sample numbering
    a_last_clears_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept_last |=> (r_index == '0) && !r_peak_seen)
        else $error("waveform state not cleared after last sample");

    // sample counter saturates at the waveform limit
    a_index_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_index <= IdxMax)
        else $error("sample index beyond limit");

    // no peak found means a zero peak
    a_peak_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |-> (r_out_peak == '0))
        else $error("peak reported without a sample in the window");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |-> !accept_last)
        else $error("result overwritten while stalled");

endmodule
